// ----- rtl/core/cau_pkg.sv -----
// Shared constants, stage record and saturation helper for the complex arithmetic unit.
package cau_pkg;

    localparam int DW    = 16;           // operand and result width
    localparam int FB    = 8;            // fractional bits
    localparam int PW    = 2 * DW;       // product width
    localparam int SW    = PW + 1;       // sum of two products
    localparam int NW    = PW + FB;      // scaled dividend width
    localparam int QB    = DW + 1;       // quotient bits kept before saturation
    localparam int OW    = PW + QB - FB; // divide overflow compare width
    localparam int RW    = DW + 3;       // square root remainder width
    localparam int STEPS = QB;           // iteration stages
    localparam int NST   = STEPS + 4;    // total register stages

    localparam logic [2:0] OP_ADD  = 3'd0;
    localparam logic [2:0] OP_SUB  = 3'd1;
    localparam logic [2:0] OP_MUL  = 3'd2;
    localparam logic [2:0] OP_DIV  = 3'd3;
    localparam logic [2:0] OP_CONJ = 3'd4;
    localparam logic [2:0] OP_NEG  = 3'd5;
    localparam logic [2:0] OP_MOD  = 3'd6;
    localparam logic [2:0] OP_RSV  = 3'd7;   // unused opcode, yields zero

    localparam logic [1:0] ST_OK  = 2'd0;
    localparam logic [1:0] ST_OVF = 2'd1;
    localparam logic [1:0] ST_DZ  = 2'd2;

    localparam logic [DW-1:0] SMAX     = {1'b0, {(DW-1){1'b1}}};
    localparam logic [DW-1:0] SMIN     = {1'b1, {(DW-1){1'b0}}};
    localparam logic [QB-1:0] MAG_PMAX = {2'b00, {(DW-1){1'b1}}};
    localparam logic [QB-1:0] MAG_NMAX = {2'b01, {(DW-1){1'b0}}};

    // One item as it moves through the iteration stages
    typedef struct packed {
        logic [2:0]    op;
        logic [DW-1:0] fx_re;
        logic [DW-1:0] fx_im;
        logic          fx_ovf;
        logic          dz;
        logic          dov_re;
        logic          dov_im;
        logic          neg_re;
        logic          neg_im;
        logic [NW-1:0] n_re;
        logic [NW-1:0] n_im;
        logic [PW-1:0] d;
        logic [PW-1:0] r_re;
        logic [PW-1:0] r_im;
        logic [QB-1:0] q_re;
        logic [QB-1:0] q_im;
        logic [PW-1:0] sx;
        logic [RW-1:0] srem;
        logic [DW-1:0] sroot;
    } t_it;

    // Saturate a sign and magnitude to DW bits; result is {overflow, value}
    function automatic logic [DW:0] f_sat(input logic neg, input logic big,
                                          input logic [QB-1:0] mag);
        logic [DW-1:0] nv;
        logic [DW:0]   res;
        nv = '0 - mag[DW-1:0];
        if (!neg) begin
            if (big || (mag > MAG_PMAX)) res = {1'b1, SMAX};
            else                         res = {1'b0, mag[DW-1:0]};
        end else begin
            if (big || (mag > MAG_NMAX)) res = {1'b1, SMIN};
            else                         res = {1'b0, nv};
        end
        return res;
    endfunction

endpackage

// ----- rtl/core/complex_arithmetic_unit_core.sv -----
// Pipelined complex arithmetic unit: add, sub, mul, div, conjugate, negate, modulus.
//
// Usage: present i_op and the operands i_a_re/i_a_im/i_b_re/i_b_im with i_valid;
// a transfer happens when i_valid and o_ready are both high. Each transfer yields
// exactly one result on o_res_re/o_res_im/o_status, offered with o_valid and taken
// when i_ready is high. Operands and results are signed Q8.8.
// Pipeline: 21 register stages (multiply stage, sum stage, setup stage, 17 restoring
// divide / square root steps, saturation stage). Throughput is one item per cycle
// while i_ready stays high: every stage carries its own valid bit and the divider and
// square root are unrolled one quotient or root bit per stage. When the receiver
// holds i_ready low the output is held; earlier stages keep filling bubbles, and
// o_ready drops only once every stage is occupied.
// Reset (i_rst_n low, synchronous) clears all valid bits; data registers are
// not reset. Status: 0 ok, 1 saturated, 2 divide by zero (result zero).
module complex_arithmetic_unit_core
    import cau_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_valid,
    output logic                 o_ready,
    input  logic [2:0]           i_op,
    input  logic signed [DW-1:0] i_a_re,
    input  logic signed [DW-1:0] i_a_im,
    input  logic signed [DW-1:0] i_b_re,
    input  logic signed [DW-1:0] i_b_im,
    output logic                 o_valid,
    input  logic                 i_ready,
    output logic signed [DW-1:0] o_res_re,
    output logic signed [DW-1:0] o_res_im,
    output logic [1:0]           o_status
);

    logic [NST-1:0] r_v;
    logic [NST-1:0] en;

    // stage A registers
    logic [2:0]           r_a_op;
    logic signed [DW-1:0] r_a_are, r_a_aim, r_a_bre, r_a_bim;
    logic signed [PW-1:0] r_a_prr, r_a_pii, r_a_pri, r_a_pir;
    logic signed [PW-1:0] r_a_pbr, r_a_pbi, r_a_par, r_a_pai;

    // stage B registers
    logic [2:0]           r_b_op;
    logic [DW-1:0]        r_b_fx_re, r_b_fx_im;
    logic                 r_b_fx_ovf;
    logic signed [SW-1:0] r_b_s_re, r_b_s_im;
    logic [PW-1:0]        r_b_d, r_b_x;

    // iteration stages and output
    t_it           r_it [0:STEPS];
    t_it           n_it [0:STEPS];
    logic [DW-1:0] r_o_re, r_o_im;
    logic [1:0]    r_o_st;

    // stage enables: a stage loads when empty or when its successor loads
    always_comb begin
        en[NST-1] = !r_v[NST-1] || i_ready;
        for (int i = NST - 2; i >= 0; i--) begin
            en[i] = !r_v[i] || en[i+1];
        end
    end

    assign o_ready = en[0];
    assign o_valid = r_v[NST-1];

    // advance valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else begin
            if (en[0]) r_v[0] <= i_valid;
            for (int i = 1; i < NST; i++) begin
                if (en[i]) r_v[i] <= r_v[i-1];
            end
        end
    end

    // stage A: register operands and all products
    always_ff @(posedge i_clk) begin
        if (en[0]) begin
            r_a_op  <= i_op;
            r_a_are <= i_a_re;
            r_a_aim <= i_a_im;
            r_a_bre <= i_b_re;
            r_a_bim <= i_b_im;
            r_a_prr <= i_a_re * i_b_re;
            r_a_pii <= i_a_im * i_b_im;
            r_a_pri <= i_a_re * i_b_im;
            r_a_pir <= i_a_im * i_b_re;
            r_a_pbr <= i_b_re * i_b_re;
            r_a_pbi <= i_b_im * i_b_im;
            r_a_par <= i_a_re * i_a_re;
            r_a_pai <= i_a_im * i_a_im;
        end
    end

    // stage B: simple ops, product sums, divisor and radicand
    logic signed [DW:0] b_sum_re, b_sum_im;
    logic [DW-1:0]      b_fx_re, b_fx_im;
    logic               b_ovf_re, b_ovf_im;

    always_comb begin
        b_fx_re  = '0;
        b_fx_im  = '0;
        b_ovf_re = 1'b0;
        b_ovf_im = 1'b0;
        if (r_a_op == OP_SUB) begin
            b_sum_re = (DW+1)'(r_a_are) - (DW+1)'(r_a_bre);
            b_sum_im = (DW+1)'(r_a_aim) - (DW+1)'(r_a_bim);
        end else begin
            b_sum_re = (DW+1)'(r_a_are) + (DW+1)'(r_a_bre);
            b_sum_im = (DW+1)'(r_a_aim) + (DW+1)'(r_a_bim);
        end
        case (r_a_op)
            OP_ADD, OP_SUB: begin
                b_ovf_re = b_sum_re[DW] != b_sum_re[DW-1];
                b_ovf_im = b_sum_im[DW] != b_sum_im[DW-1];
                b_fx_re  = b_ovf_re ? (b_sum_re[DW] ? SMIN : SMAX) : b_sum_re[DW-1:0];
                b_fx_im  = b_ovf_im ? (b_sum_im[DW] ? SMIN : SMAX) : b_sum_im[DW-1:0];
            end
            OP_CONJ, OP_NEG: begin
                if (r_a_op == OP_CONJ) begin
                    b_fx_re = r_a_are;
                end else begin
                    b_ovf_re = r_a_are == SMIN;
                    b_fx_re  = b_ovf_re ? SMAX : ('0 - r_a_are);
                end
                b_ovf_im = r_a_aim == SMIN;
                b_fx_im  = b_ovf_im ? SMAX : ('0 - r_a_aim);
            end
            default: begin
                b_fx_re = '0;
                b_fx_im = '0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (en[1]) begin
            r_b_op     <= r_a_op;
            r_b_fx_re  <= b_fx_re;
            r_b_fx_im  <= b_fx_im;
            r_b_fx_ovf <= b_ovf_re || b_ovf_im;
            if (r_a_op == OP_MUL) begin
                r_b_s_re <= SW'(r_a_prr) - SW'(r_a_pii);
                r_b_s_im <= SW'(r_a_pri) + SW'(r_a_pir);
            end else begin
                r_b_s_re <= SW'(r_a_prr) + SW'(r_a_pii);
                r_b_s_im <= SW'(r_a_pir) - SW'(r_a_pri);
            end
            r_b_d <= PW'($unsigned(r_a_pbr)) + PW'($unsigned(r_a_pbi));
            r_b_x <= PW'($unsigned(r_a_par)) + PW'($unsigned(r_a_pai));
        end
    end

    // stage C: magnitudes, multiply saturation, divide setup
    logic [PW-1:0] c_mag_re, c_mag_im, c_mm_re, c_mm_im;
    logic [DW:0]   c_ms_re, c_ms_im;
    logic [NW-1:0] c_n_re, c_n_im;

    always_comb begin
        c_mag_re = r_b_s_re[SW-1] ? PW'(-r_b_s_re) : PW'(r_b_s_re);
        c_mag_im = r_b_s_im[SW-1] ? PW'(-r_b_s_im) : PW'(r_b_s_im);
        c_mm_re  = c_mag_re >> FB;
        c_mm_im  = c_mag_im >> FB;
        c_ms_re  = f_sat(r_b_s_re[SW-1], |c_mm_re[PW-1:QB], c_mm_re[QB-1:0]);
        c_ms_im  = f_sat(r_b_s_im[SW-1], |c_mm_im[PW-1:QB], c_mm_im[QB-1:0]);
        c_n_re   = {c_mag_re, {FB{1'b0}}};
        c_n_im   = {c_mag_im, {FB{1'b0}}};

        n_it[0].op     = r_b_op;
        n_it[0].fx_re  = (r_b_op == OP_MUL) ? c_ms_re[DW-1:0] : r_b_fx_re;
        n_it[0].fx_im  = (r_b_op == OP_MUL) ? c_ms_im[DW-1:0] : r_b_fx_im;
        n_it[0].fx_ovf = (r_b_op == OP_MUL) ? (c_ms_re[DW] || c_ms_im[DW]) : r_b_fx_ovf;
        n_it[0].dz     = r_b_d == '0;
        n_it[0].dov_re = OW'(c_mag_re) >= (OW'(r_b_d) << (QB - FB));
        n_it[0].dov_im = OW'(c_mag_im) >= (OW'(r_b_d) << (QB - FB));
        n_it[0].neg_re = r_b_s_re[SW-1];
        n_it[0].neg_im = r_b_s_im[SW-1];
        n_it[0].n_re   = c_n_re;
        n_it[0].n_im   = c_n_im;
        n_it[0].d      = r_b_d;
        n_it[0].r_re   = PW'(c_n_re >> QB);
        n_it[0].r_im   = PW'(c_n_im >> QB);
        n_it[0].q_re   = '0;
        n_it[0].q_im   = '0;
        n_it[0].sx     = r_b_x;
        n_it[0].srem   = '0;
        n_it[0].sroot  = '0;
    end

    always_ff @(posedge i_clk) begin
        if (en[2]) r_it[0] <= n_it[0];
    end

    // iteration stages: one quotient bit per component each, and one root bit in each of the first DW
    for (genvar k = 0; k < STEPS; k++) begin : g_step
        logic [PW:0]   t_re, t_im, dd;
        logic [RW-1:0] s_rem, s_trial;

        always_comb begin
            n_it[k+1] = r_it[k];
            dd   = {1'b0, r_it[k].d};
            t_re = {r_it[k].r_re, r_it[k].n_re[QB-1-k]};
            t_im = {r_it[k].r_im, r_it[k].n_im[QB-1-k]};
            if (t_re >= dd) begin
                n_it[k+1].r_re = PW'(t_re - dd);
                n_it[k+1].q_re = {r_it[k].q_re[QB-2:0], 1'b1};
            end else begin
                n_it[k+1].r_re = PW'(t_re);
                n_it[k+1].q_re = {r_it[k].q_re[QB-2:0], 1'b0};
            end
            if (t_im >= dd) begin
                n_it[k+1].r_im = PW'(t_im - dd);
                n_it[k+1].q_im = {r_it[k].q_im[QB-2:0], 1'b1};
            end else begin
                n_it[k+1].r_im = PW'(t_im);
                n_it[k+1].q_im = {r_it[k].q_im[QB-2:0], 1'b0};
            end
            s_rem   = '0;
            s_trial = '0;
            if (k < DW) begin
                // take the top bit pair of the radicand and shift the rest up
                s_rem   = {r_it[k].srem[DW:0], r_it[k].sx[PW-1 -: 2]};
                s_trial = RW'({r_it[k].sroot, 2'b01});
                n_it[k+1].sx = r_it[k].sx << 2;
                if (s_rem >= s_trial) begin
                    n_it[k+1].srem  = s_rem - s_trial;
                    n_it[k+1].sroot = {r_it[k].sroot[DW-2:0], 1'b1};
                end else begin
                    n_it[k+1].srem  = s_rem;
                    n_it[k+1].sroot = {r_it[k].sroot[DW-2:0], 1'b0};
                end
            end
        end

        always_ff @(posedge i_clk) begin
            if (en[3+k]) r_it[k+1] <= n_it[k+1];
        end
    end

    // output stage: select, saturate and report
    logic [DW:0]   o_sr, o_si, o_sm;
    logic [DW-1:0] f_re, f_im;
    logic [1:0]    f_st;

    always_comb begin
        o_sr = f_sat(r_it[STEPS].neg_re, r_it[STEPS].dov_re, r_it[STEPS].q_re);
        o_si = f_sat(r_it[STEPS].neg_im, r_it[STEPS].dov_im, r_it[STEPS].q_im);
        o_sm = f_sat(1'b0, 1'b0, {1'b0, r_it[STEPS].sroot});
        case (r_it[STEPS].op)
            OP_ADD, OP_SUB, OP_MUL, OP_CONJ, OP_NEG: begin
                f_re = r_it[STEPS].fx_re;
                f_im = r_it[STEPS].fx_im;
                f_st = r_it[STEPS].fx_ovf ? ST_OVF : ST_OK;
            end
            OP_DIV: begin
                if (r_it[STEPS].dz) begin
                    f_re = '0;
                    f_im = '0;
                    f_st = ST_DZ;
                end else begin
                    f_re = o_sr[DW-1:0];
                    f_im = o_si[DW-1:0];
                    f_st = (o_sr[DW] || o_si[DW]) ? ST_OVF : ST_OK;
                end
            end
            OP_MOD: begin
                f_re = o_sm[DW-1:0];
                f_im = '0;
                f_st = o_sm[DW] ? ST_OVF : ST_OK;
            end
            default: begin
                f_re = '0;
                f_im = '0;
                f_st = ST_OK;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (en[NST-1]) begin
            r_o_re <= f_re;
            r_o_im <= f_im;
            r_o_st <= f_st;
        end
    end

    assign o_res_re = r_o_re;
    assign o_res_im = r_o_im;
    assign o_status = r_o_st;

    // a divide by zero always comes with a zero result
    a_dz_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && (o_status == ST_DZ) |-> (o_res_re == '0) && (o_res_im == '0))
        else $error("divide by zero result not zero");

    // status never takes the unused code
    a_st_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_status == ST_OK) || (o_status == ST_OVF) || (o_status == ST_DZ))
        else $error("bad status code");

    // input is refused only when every stage is full and the output is stalled
    a_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_ready |-> (&r_v) && !i_ready)
        else $error("input refused with a bubble in the pipeline");

    // a held result moves out only through a transfer
    a_drain: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid)
        else $error("result dropped without transfer");

endmodule

// ----- tb/complex_arithmetic_unit_core_test.sv -----
// Self-checking testbench for the complex arithmetic unit core with random handshake stalls.
class cau_scoreboard;
    logic [15:0] exp_re [$];
    logic [15:0] exp_im [$];
    logic [1:0]  exp_st [$];
    int          n_err;

    function new();
        n_err = 0;
    endfunction

    // Saturate a signed value to the 16-bit range
    function automatic logic [16:0] clamp(input longint v);
        if (v > 32767)  return {1'b1, 16'h7fff};
        if (v < -32768) return {1'b1, 16'h8000};
        return {1'b0, v[15:0]};
    endfunction

    // Truncate toward zero: n * 256 / d
    function automatic longint tdiv(input longint n, input longint d);
        longint mag, q;
        mag = (n < 0) ? -n : n;
        q = (mag * 256) / d;
        return (n < 0) ? -q : q;
    endfunction

    // Integer square root, floor; the radicand stays below 2^32
    function automatic longint root(input longint x);
        longint r;
        r = 0;
        for (longint b = 64'sd1 << 16; b > 0; b = b >> 1)
            if ((r + b) * (r + b) <= x) r = r + b;
        return r;
    endfunction

    // Compute the expected result of one transfer
    function void note_input(input logic [2:0] op, input logic signed [15:0] ar,
                             input logic signed [15:0] ai, input logic signed [15:0] br,
                             input logic signed [15:0] bi);
        longint re, im, d;
        logic [16:0] sr, si;
        logic [1:0]  st;
        re = 0; im = 0; st = cau_pkg::ST_OK;
        case (op)
            cau_pkg::OP_ADD: begin re = ar + br; im = ai + bi; end
            cau_pkg::OP_SUB: begin re = longint'(ar) - br; im = longint'(ai) - bi; end
            cau_pkg::OP_MUL: begin
                re = longint'(ar) * br - longint'(ai) * bi;
                im = longint'(ar) * bi + longint'(ai) * br;
                re = (re < 0) ? -((-re) >>> 8) : re >>> 8;
                im = (im < 0) ? -((-im) >>> 8) : im >>> 8;
            end
            cau_pkg::OP_DIV: begin
                d = longint'(br) * br + longint'(bi) * bi;
                if (d == 0) st = cau_pkg::ST_DZ;
                else begin
                    re = tdiv(longint'(ar) * br + longint'(ai) * bi, d);
                    im = tdiv(longint'(ai) * br - longint'(ar) * bi, d);
                end
            end
            cau_pkg::OP_CONJ: begin re = ar; im = -longint'(ai); end
            cau_pkg::OP_NEG: begin re = -longint'(ar); im = -longint'(ai); end
            cau_pkg::OP_MOD: re = root(longint'(ar) * ar + longint'(ai) * ai);
            default: ;
        endcase
        sr = clamp(re);
        si = clamp(im);
        if (st == cau_pkg::ST_OK && (sr[16] || si[16])) st = cau_pkg::ST_OVF;
        exp_re.push_back(sr[15:0]);
        exp_im.push_back(si[15:0]);
        exp_st.push_back(st);
    endfunction

    task report(input string what, input logic [15:0] got, input logic [15:0] want);
        $display("mismatch in %s: got %h, want %h", what, got, want);
        n_err++;
    endtask

    // Compare one output transfer against the oldest expectation
    task check_result(input logic [15:0] re, input logic [15:0] im, input logic [1:0] st);
        logic [15:0] wr, wi;
        logic [1:0]  ws;
        if (exp_re.size() == 0) begin
            report("unexpected result", re, 16'h0);
            return;
        end
        wr = exp_re.pop_front();
        wi = exp_im.pop_front();
        ws = exp_st.pop_front();
        if (re !== wr) report("res_re", re, wr);
        if (im !== wi) report("res_im", im, wi);
        if (st !== ws) report("status", {14'b0, st}, {14'b0, ws});
    endtask
endclass

module complex_arithmetic_unit_core_test;
    import cau_pkg::*;

    localparam int LIMIT = 400000;

    logic                 i_clk = 1'b0;
    logic                 i_rst_n = 1'b0;
    logic                 i_valid = 1'b0;
    logic                 o_ready;
    logic [2:0]           i_op = '0;
    logic signed [DW-1:0] i_a_re = '0;
    logic signed [DW-1:0] i_a_im = '0;
    logic signed [DW-1:0] i_b_re = '0;
    logic signed [DW-1:0] i_b_im = '0;
    logic                 o_valid;
    logic                 i_ready = 1'b0;
    logic signed [DW-1:0] o_res_re;
    logic signed [DW-1:0] o_res_im;
    logic [1:0]           o_status;

    cau_scoreboard results = new();
    int  cycles = 0;
    bit  rx_on = 1'b0;

    complex_arithmetic_unit_core DUT (.*);

    always #1 i_clk = ~i_clk;

    // Stop a hung run
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > LIMIT) begin
            $display("Mismatches found");
            $finish;
        end
    end

    function automatic int gap_len();
        if ($urandom_range(0, 9) < 4) return 0;
        if ($urandom_range(0, 19) == 0) return $urandom_range(10, 40);
        return $urandom_range(1, 3);
    endfunction

    // Check output transfers and drive random back pressure
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && i_ready)
            results.check_result(o_res_re, o_res_im, o_status);
        if (!rx_on) i_ready <= 1'b0;
        else if (gap_len() == 0) i_ready <= 1'b1;
        else i_ready <= ($urandom_range(0, 2) == 0);
    end

    function automatic logic [15:0] pick_val();
        case ($urandom_range(0, 7))
            0: return 16'h8000;
            1: return 16'h7fff;
            2: return 16'h0000;
            3: return 16'($urandom_range(0, 1023)) - 16'd512;
            default: return 16'($urandom);
        endcase
    endfunction

    // Present one item and hold it until the transfer; drop valid only for a gap
    task send(input logic [2:0] op, input logic [15:0] ar, input logic [15:0] ai,
              input logic [15:0] br, input logic [15:0] bi);
        int g;
        g = gap_len();
        if (g > 0) begin
            i_valid <= 1'b0;
            repeat (g) @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_op <= op; i_a_re <= ar; i_a_im <= ai; i_b_re <= br; i_b_im <= bi;
        do @(posedge i_clk); while (!o_ready);
        results.note_input(op, ar, ai, br, bi);
    endtask

    initial begin
        logic [2:0] op;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        rx_on = 1'b1;
        // Directed: extremes, every op, special cases
        send(OP_ADD, 16'h7fff, 16'h8000, 16'h7fff, 16'h8000);
        send(OP_ADD, 16'h0100, 16'hff00, 16'h0080, 16'h0040);
        send(OP_SUB, 16'h8000, 16'h7fff, 16'h7fff, 16'h8000);
        send(OP_SUB, 16'h0100, 16'h0200, 16'h0100, 16'h0100);
        send(OP_MUL, 16'h8000, 16'h8000, 16'h8000, 16'h8000);
        send(OP_MUL, 16'h0100, 16'h0200, 16'hff00, 16'h0080);
        send(OP_MUL, 16'hffff, 16'h0000, 16'h0001, 16'h0000);
        send(OP_DIV, 16'h0100, 16'h0100, 16'h0000, 16'h0000);
        send(OP_DIV, 16'h7fff, 16'h8000, 16'h0001, 16'h0000);
        send(OP_DIV, 16'h0300, 16'hfd00, 16'h0100, 16'h0200);
        send(OP_DIV, 16'h8000, 16'h8000, 16'h8000, 16'h8000);
        send(OP_CONJ, 16'h8000, 16'h8000, 16'h0, 16'h0);
        send(OP_CONJ, 16'h1234, 16'hff00, 16'h0, 16'h0);
        send(OP_NEG, 16'h8000, 16'h7fff, 16'h0, 16'h0);
        send(OP_NEG, 16'h0001, 16'hffff, 16'hffff, 16'hffff);
        send(OP_MOD, 16'h8000, 16'h8000, 16'h0, 16'h0);
        send(OP_MOD, 16'h0300, 16'h0400, 16'h0, 16'h0);
        send(OP_MOD, 16'h0000, 16'h0000, 16'h0, 16'h0);
        send(OP_RSV, 16'hffff, 16'hffff, 16'hffff, 16'hffff);
        // Random items
        repeat (1000) begin
            op = ($urandom_range(0, 40) == 0) ? OP_RSV : 3'($urandom_range(0, 6));
            if (op == OP_DIV && $urandom_range(0, 15) == 0)
                send(op, pick_val(), pick_val(), 16'h0, 16'h0);
            else
                send(op, pick_val(), pick_val(), pick_val(), pick_val());
        end
        i_valid <= 1'b0;
        // Drain outstanding results
        while (results.exp_re.size() != 0) @(posedge i_clk);
        repeat (30) @(posedge i_clk);
        if (results.n_err == 0) $display("No mismatches found");
        else $display("Mismatches found");
        $finish;
    end
endmodule
